FILE: rtl/spq_pkg.sv
package spq_pkg;

   localparam int DEPTH         = 16;
   localparam int PRIORITY_BITS = 8;
   localparam int TAG_BITS      = 16;
   localparam int COUNT_BITS    = $clog2(DEPTH + 1);

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_REMOVED  = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef struct packed {
      logic [PRIORITY_BITS-1:0] prio;
      logic [TAG_BITS-1:0]      tag;
   } entry_type;

   typedef struct packed {
      logic      insert;
      logic      remove;
      entry_type new_entry;
   } cell_ctrl_type;

endpackage

FILE: rtl/spq_cell.sv
module spq_cell
   import spq_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic          valid,
   input  logic          left_ge,
   input  entry_type     left_entry,
   input  entry_type     right_entry,
   output entry_type     entry,
   output logic          own_ge
);

   entry_type entry_ff;
   entry_type entry_in;

   assign own_ge = valid && (entry_ff.prio >= ctrl.new_entry.prio);
   assign entry  = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert) begin
         if (own_ge) begin
            entry_in = entry_ff;
         end else if (left_ge) begin
            entry_in = ctrl.new_entry;
         end else begin
            entry_in = left_entry;
         end
      end else if (ctrl.remove) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

FILE: rtl/stable_priority_queue_unit.sv
// channel   ports                                         beat taken when
// request   start, busy, req_operation/priority_req/tag   start && !busy
// response  rsp_valid, rsp_status/out_tag/out_priority/   rsp_valid high
//           rsp_occupancy
//
// one request per cycle; busy stays low
// the response appears in the cycle after its request, for one cycle
// sync reset empties the queue; cell contents are not cleared
// no stall on the response side
module stable_priority_queue_unit
   import spq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_operation,
   input  logic [PRIORITY_BITS-1:0] req_priority_req,
   input  logic [TAG_BITS-1:0]      req_tag,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_status,
   output logic [TAG_BITS-1:0]      rsp_out_tag,
   output logic [PRIORITY_BITS-1:0] rsp_out_priority,
   output logic [COUNT_BITS-1:0]    rsp_occupancy
);

   logic                     accept;
   logic                     is_full;
   logic                     is_empty;
   cell_ctrl_type            ctrl;
   logic [COUNT_BITS-1:0]    count_ff;
   logic [COUNT_BITS-1:0]    count_in;
   logic                     rsp_valid_ff;
   status_type               status_ff;
   status_type               status_in;
   logic [TAG_BITS-1:0]      tag_ff;
   logic [TAG_BITS-1:0]      tag_in;
   logic [PRIORITY_BITS-1:0] prio_ff;
   logic [PRIORITY_BITS-1:0] prio_in;

   entry_type cell_entry [DEPTH];
   logic      cell_ge    [DEPTH];
   logic      cell_valid [DEPTH];

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign is_full  = (count_ff == COUNT_BITS'(DEPTH));
   assign is_empty = (count_ff == '0);

   assign ctrl.insert         = accept && (req_operation == OP_INSERT) && !is_full;
   assign ctrl.remove         = accept && (req_operation == OP_REMOVE) && !is_empty;
   assign ctrl.new_entry.prio = req_priority_req;
   assign ctrl.new_entry.tag  = req_tag;

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         entry_type left_entry;
         entry_type right_entry;
         logic      left_ge;

         assign cell_valid[g] = (COUNT_BITS'(g) < count_ff);

         if (g == 0) begin : g_first
            assign left_entry = ctrl.new_entry;
            assign left_ge    = 1'b1;
         end else begin : g_mid
            assign left_entry = cell_entry[g-1];
            assign left_ge    = cell_ge[g-1];
         end

         if (g == DEPTH - 1) begin : g_last
            assign right_entry = cell_entry[g];
         end else begin : g_inner
            assign right_entry = cell_entry[g+1];
         end

         spq_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .valid       (cell_valid[g]),
            .left_ge     (left_ge),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (cell_entry[g]),
            .own_ge      (cell_ge[g])
         );
      end
   endgenerate

   always_comb begin
      count_in  = count_ff;
      status_in = ST_INSERTED;
      tag_in    = '0;
      prio_in   = '0;
      if (req_operation == OP_INSERT) begin
         if (is_full) begin
            status_in = ST_FULL;
         end else begin
            status_in = ST_INSERTED;
            count_in  = count_ff + COUNT_BITS'(1);
         end
      end else begin
         if (is_empty) begin
            status_in = ST_EMPTY;
         end else begin
            status_in = ST_REMOVED;
            tag_in    = cell_entry[0].tag;
            prio_in   = cell_entry[0].prio;
            count_in  = count_ff - COUNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         tag_ff    <= tag_in;
         prio_ff   <= prio_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_tag      = tag_ff;
   assign rsp_out_priority = prio_ff;
   assign rsp_occupancy    = count_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(DEPTH))
      else $error("count above depth");

   a_front_sorted: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= COUNT_BITS'(2)) |-> (cell_entry[0].prio >= cell_entry[1].prio))
      else $error("front entries out of order");

   a_remove_count: assert property (@(posedge clock) disable iff (reset)
      (accept && req_operation == OP_REMOVE && !is_empty) |=>
         (rsp_status == ST_REMOVED && rsp_occupancy == $past(count_ff) - COUNT_BITS'(1)))
      else $error("remove result mismatch");

   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && req_operation == OP_INSERT && is_full) |=>
         (rsp_status == ST_FULL && count_ff == COUNT_BITS'(DEPTH)))
      else $error("insert on full changed state");
`endif

endmodule
